FILE: design/rcr_pkg.sv
// Shared types and constants for the robust correspondence reweight core.
// Used by rcr_front, rcr_queue, rcr_back and robust_correspondence_reweight_core.
package rcr_pkg;

    localparam int NUM_W = 47;
    localparam int DEN_W = 51;
    localparam int QUO_W = 16;

    localparam int QUEUE_DEPTH_DEF = 8;
    localparam int OUT_DEPTH_DEF   = 32;

    localparam logic [15:0] WEIGHT_ONE = 16'd32768;

    localparam logic [1:0] MODE_BR  = 2'd0;
    localparam logic [1:0] MODE_HUB = 2'd1;
    localparam logic [1:0] MODE_BIS = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_MU    = 2'd1;
    localparam logic [1:0] REG_BOUND = 2'd2;

    localparam logic [30:0] MU_RESET    = 31'd65536;
    localparam logic [30:0] BOUND_RESET = 31'd65536;

    typedef enum logic [2:0] {
        OP_ZERO,
        OP_PASS,
        OP_BR,
        OP_HUB,
        OP_BIS
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [15:0]      w;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } entry_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } qstat_t;

endpackage

FILE: design/rcr_front.sv
// Front end: accepts correspondences, forms distances and classifies each item.
// Depends on rcr_pkg.
module rcr_front #(
    parameter int DEPTH = rcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [31:0]   model_x,
    input  logic signed [31:0]   model_y,
    input  logic signed [31:0]   model_z,
    input  logic signed [31:0]   target_x,
    input  logic signed [31:0]   target_y,
    input  logic signed [31:0]   target_z,
    input  logic [15:0]          old_weight,
    input  logic [1:0]           mode,
    input  logic [30:0]          mu,
    input  logic [30:0]          bound,
    input  logic                 pop,
    output logic                 push,
    output rcr_pkg::entry_t      push_entry
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]       credit_reg, credit_next;
    logic                accept;
    logic [3:0]          v_reg;
    logic signed [31:0]  m_reg [3];
    logic signed [31:0]  t_reg [3];
    logic [15:0]         w0_reg, w1_reg, w2_reg, w3_reg;
    logic [31:0]         d_reg [3];
    logic [63:0]         sq_reg [3];
    logic [31:0]         m2_reg, m3_reg;
    logic [49:0]         s3_reg;
    logic [31:0]         d_next [3];
    logic [31:0]         max_next;
    logic [65:0]         sum_next;

    function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
        logic signed [32:0] d;
        d = 33'(a) - 33'(b);
        abs_diff = d[32] ? 32'(-d) : d[31:0];
    endfunction

    assign in_stall = (credit_reg == CW'(DEPTH));
    assign accept   = in_valid && !in_stall;

    // Reserve a queue slot per accepted item, release it on pop
    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !pop)
        begin
            credit_next = credit_reg + CW'(1);
        end
        else if (!accept && pop)
        begin
            credit_next = credit_reg - CW'(1);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_next[i] = abs_diff(m_reg[i], t_reg[i]);
        end
        max_next = d_reg[0];
        if (d_reg[1] > max_next)
        begin
            max_next = d_reg[1];
        end
        if (d_reg[2] > max_next)
        begin
            max_next = d_reg[2];
        end
        sum_next = 66'(sq_reg[0]) + 66'(sq_reg[1]) + 66'(sq_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            v_reg      <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
            v_reg      <= {v_reg[2:0], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_reg[0] <= model_x;
            m_reg[1] <= model_y;
            m_reg[2] <= model_z;
            t_reg[0] <= target_x;
            t_reg[1] <= target_y;
            t_reg[2] <= target_z;
            w0_reg   <= old_weight;
        end
        for (int i = 0; i < 3; i++)
        begin
            d_reg[i]  <= d_next[i];
            sq_reg[i] <= 64'(d_reg[i]) * 64'(d_reg[i]);
        end
        w1_reg <= w0_reg;
        w2_reg <= w1_reg;
        m2_reg <= max_next;
        w3_reg <= w2_reg;
        m3_reg <= m2_reg;
        s3_reg <= sum_next[65:16];
    end

    // Classify: pick the operation and the operands of the shared divider
    always_comb
    begin
        logic [rcr_pkg::DEN_W-1:0] den_sum;
        logic [rcr_pkg::NUM_W-1:0] prod_wb;
        logic                      m_lt_b;
        den_sum = rcr_pkg::DEN_W'(s3_reg) + rcr_pkg::DEN_W'(mu);
        prod_wb = rcr_pkg::NUM_W'(w3_reg) * rcr_pkg::NUM_W'(bound);
        m_lt_b  = m3_reg < {1'b0, bound};
        push    = v_reg[3];
        push_entry.op  = rcr_pkg::OP_ZERO;
        push_entry.w   = w3_reg;
        push_entry.num = '0;
        push_entry.den = '0;
        case (mode)
            rcr_pkg::MODE_BR:
            begin
                if (w3_reg != 16'd0)
                begin
                    push_entry.op = rcr_pkg::OP_BR;
                    if (den_sum == '0)
                    begin
                        push_entry.num = rcr_pkg::NUM_W'(rcr_pkg::WEIGHT_ONE);
                        push_entry.den = rcr_pkg::DEN_W'(1);
                    end
                    else
                    begin
                        push_entry.num = rcr_pkg::NUM_W'({mu, 15'd0});
                        push_entry.den = den_sum;
                    end
                end
            end
            rcr_pkg::MODE_HUB:
            begin
                if (m_lt_b || m3_reg == 32'd0)
                begin
                    push_entry.op = rcr_pkg::OP_PASS;
                end
                else
                begin
                    push_entry.op  = rcr_pkg::OP_HUB;
                    push_entry.num = prod_wb;
                    push_entry.den = rcr_pkg::DEN_W'(m3_reg);
                end
            end
            rcr_pkg::MODE_BIS:
            begin
                if (m_lt_b)
                begin
                    push_entry.op  = rcr_pkg::OP_BIS;
                    push_entry.num = rcr_pkg::NUM_W'({m3_reg, 15'd0});
                    push_entry.den = rcr_pkg::DEN_W'(bound);
                end
            end
            default:
            begin
                push_entry.op = rcr_pkg::OP_ZERO;
            end
        endcase
    end

endmodule

FILE: design/rcr_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on rcr_pkg.
module rcr_queue #(
    parameter int DEPTH = rcr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rcr_pkg::entry_t push_entry,
    input  logic            pop,
    output rcr_pkg::entry_t head,
    output rcr_pkg::qstat_t stat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    rcr_pkg::entry_t mem [DEPTH];
    logic [PW-1:0]   wp_reg, rp_reg;
    logic [CW-1:0]   cnt_reg;

    assign head           = mem[rp_reg];
    assign stat.not_empty = (cnt_reg != '0);
    assign stat.full      = (cnt_reg == CW'(DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + PW'(1);
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (!push && pop)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= push_entry;
        end
    end

endmodule

FILE: design/rcr_back.sv
// Back end: pipelined restoring divider, weight products and result FIFO.
// Depends on rcr_pkg.
module rcr_back #(
    parameter int OUT_DEPTH = rcr_pkg::OUT_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rcr_pkg::qstat_t q_stat,
    input  rcr_pkg::entry_t head,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [15:0]     updated_weight
);

    localparam int NW = rcr_pkg::NUM_W;
    localparam int DW = rcr_pkg::DEN_W;
    localparam int QW = rcr_pkg::QUO_W;
    localparam int TW = NW + QW + 6;
    localparam int PW = $clog2(OUT_DEPTH);
    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic [CW-1:0]    ocred_reg;
    logic [QW:0]      dv_reg;
    logic [NW-1:0]    rem_reg [QW+1];
    logic [DW-1:0]    den_reg [QW+1];
    logic [QW-1:0]    quo_reg [QW+1];
    rcr_pkg::op_t     op_reg  [QW+1];
    logic [15:0]      w_reg   [QW+1];
    logic [NW-1:0]    rem_next [QW];
    logic [QW-1:0]    quo_next [QW];

    logic [2:0]       pv_reg;
    rcr_pkg::op_t     op1_reg, op2_reg;
    logic [15:0]      w1_reg;
    logic [31:0]      a1_reg, b2_reg;
    logic [15:0]      t2_reg;
    logic [17:0]      c3_reg;
    logic [31:0]      a1_next, b2_next;
    logic [15:0]      t2_next;
    logic [17:0]      c3_next;
    logic [15:0]      sat_w;

    logic [15:0]      fifo [OUT_DEPTH];
    logic [PW-1:0]    wp_reg, rp_reg;
    logic [CW-1:0]    cnt_reg;
    logic             out_take;

    assign pop      = q_stat.not_empty && (ocred_reg < CW'(OUT_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign updated_weight = fifo[rp_reg];
    assign out_take = out_valid && !out_stall;

    // One quotient bit per stage, most significant first
    always_comb
    begin
        for (int s = 0; s < QW; s++)
        begin
            logic [TW-1:0] trial;
            trial = TW'(rem_reg[s]) - (TW'(den_reg[s]) << (QW - 1 - s));
            if (trial[TW-1])
            begin
                rem_next[s] = rem_reg[s];
                quo_next[s] = {quo_reg[s][QW-2:0], 1'b0};
            end
            else
            begin
                rem_next[s] = trial[NW-1:0];
                quo_next[s] = {quo_reg[s][QW-2:0], 1'b1};
            end
        end
    end

    always_comb
    begin
        logic [15:0] q;
        logic [15:0] f;
        logic [47:0] prod;
        q       = quo_reg[QW];
        f       = (q == 16'd0) ? 16'd1 : q;
        a1_next = 32'd0;
        case (op_reg[QW])
            rcr_pkg::OP_BR:   a1_next = 32'(w_reg[QW]) * 32'(f);
            rcr_pkg::OP_BIS:  a1_next = 32'(q) * 32'(q);
            rcr_pkg::OP_HUB:  a1_next = 32'(q);
            rcr_pkg::OP_PASS: a1_next = 32'(w_reg[QW]);
            default:          a1_next = 32'd0;
        endcase

        t2_next = rcr_pkg::WEIGHT_ONE - 16'(a1_reg >> 15);
        case (op1_reg)
            rcr_pkg::OP_BR:  b2_next = a1_reg >> 15;
            rcr_pkg::OP_BIS: b2_next = 32'(w1_reg) * 32'(t2_next);
            default:         b2_next = a1_reg;
        endcase

        prod = 48'(b2_reg) * 48'(t2_reg);
        if (op2_reg == rcr_pkg::OP_BIS)
        begin
            c3_next = prod[47:30];
        end
        else
        begin
            c3_next = b2_reg[17:0];
        end

        sat_w = (c3_reg > 18'(rcr_pkg::WEIGHT_ONE)) ? rcr_pkg::WEIGHT_ONE : c3_reg[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg    <= '0;
            pv_reg    <= '0;
            ocred_reg <= '0;
            wp_reg    <= '0;
            rp_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            dv_reg <= {dv_reg[QW-1:0], pop};
            pv_reg <= {pv_reg[1:0], dv_reg[QW]};
            if (pop && !out_take)
            begin
                ocred_reg <= ocred_reg + CW'(1);
            end
            else if (!pop && out_take)
            begin
                ocred_reg <= ocred_reg - CW'(1);
            end
            if (pv_reg[2])
            begin
                wp_reg <= (wp_reg == PW'(OUT_DEPTH - 1)) ? '0 : wp_reg + PW'(1);
            end
            if (out_take)
            begin
                rp_reg <= (rp_reg == PW'(OUT_DEPTH - 1)) ? '0 : rp_reg + PW'(1);
            end
            if (pv_reg[2] && !out_take)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            else if (!pv_reg[2] && out_take)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= head.num;
        den_reg[0] <= head.den;
        quo_reg[0] <= '0;
        op_reg[0]  <= head.op;
        w_reg[0]   <= head.w;
        for (int s = 0; s < QW; s++)
        begin
            rem_reg[s+1] <= rem_next[s];
            den_reg[s+1] <= den_reg[s];
            quo_reg[s+1] <= quo_next[s];
            op_reg[s+1]  <= op_reg[s];
            w_reg[s+1]   <= w_reg[s];
        end
        a1_reg  <= a1_next;
        op1_reg <= op_reg[QW];
        w1_reg  <= w_reg[QW];
        b2_reg  <= b2_next;
        t2_reg  <= t2_next;
        op2_reg <= op1_reg;
        c3_reg  <= c3_next;
        if (pv_reg[2])
        begin
            fifo[wp_reg] <= sat_w;
        end
    end

endmodule

FILE: design/robust_correspondence_reweight_core.sv
// Top level of the robust correspondence reweight core.
// Depends on rcr_pkg, rcr_front, rcr_queue and rcr_back.
//
// Takes one point correspondence (model point, target point, Q16.16, and a
// Q1.15 weight) per cycle while in_stall is low and returns one reweighted
// Q1.15 weight per item, in order, saturated to one. The mode register selects
// Black-Rangarajan (0), Huber on the max-abs residual (1) or bisquare on the
// max-abs residual (2); mode 3 returns zero. The sustained rate is one item per
// clock while out_stall is low. An accepted item passes five front stages (input
// register, difference, square, sum, queue write, with classification in front
// of the queue write), one queue read into the divider, sixteen divider stages
// (one quotient bit each, through a single pipelined restoring divider shared
// by all modes), three product stages and the result FIFO write. The front end
// stalls only when the classified-item queue has no reserved slot left; the
// back end only pulls from that queue while the result FIFO has room for
// everything in flight, so a stalled output fills the FIFO, then the queue,
// and only then raises in_stall. Write registers only while the block is
// idle; cfg_ready is always high.
module robust_correspondence_reweight_core #(
    parameter int QUEUE_DEPTH = rcr_pkg::QUEUE_DEPTH_DEF,
    parameter int OUT_DEPTH   = rcr_pkg::OUT_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  model_x,
    input  logic signed [31:0]  model_y,
    input  logic signed [31:0]  model_z,
    input  logic signed [31:0]  target_x,
    input  logic signed [31:0]  target_y,
    input  logic signed [31:0]  target_z,
    input  logic [15:0]         old_weight,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [15:0]         updated_weight,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);

    logic [1:0]      mode_reg;
    logic [30:0]     mu_reg;
    logic [30:0]     bound_reg;
    logic            push;
    logic            pop;
    rcr_pkg::entry_t push_entry;
    rcr_pkg::entry_t head;
    rcr_pkg::qstat_t q_stat;

    assign cfg_ready = 1'b1;

    // Register file: an index past the last register is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= rcr_pkg::MODE_BR;
            mu_reg    <= rcr_pkg::MU_RESET;
            bound_reg <= rcr_pkg::BOUND_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rcr_pkg::REG_MODE:  mode_reg  <= cfg_data[1:0];
                rcr_pkg::REG_MU:    mu_reg    <= cfg_data[30:0];
                rcr_pkg::REG_BOUND: bound_reg <= cfg_data[30:0];
                default:            ;
            endcase
        end
    end

    // Front end: accept, difference, square, sum and classify
    rcr_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .model_x    (model_x),
        .model_y    (model_y),
        .model_z    (model_z),
        .target_x   (target_x),
        .target_y   (target_y),
        .target_z   (target_z),
        .old_weight (old_weight),
        .mode       (mode_reg),
        .mu         (mu_reg),
        .bound      (bound_reg),
        .pop        (pop),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue: holds classified items until the back end pulls them
    rcr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    // Back end: divide, weight products, saturate and buffer results
    rcr_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_stat         (q_stat),
        .head           (head),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .updated_weight (updated_weight)
    );

    // The credit scheme must never overfill the queue
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !q_stat.full)
        else $error("queue written while full");

    // The back end must never pull from an empty queue
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_stat.not_empty)
        else $error("queue read while empty");

    // Every delivered weight is saturated to one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (updated_weight <= rcr_pkg::WEIGHT_ONE))
        else $error("result weight above one");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking regression for robust_correspondence_reweight_core.
// Depends on rcr_pkg and the core; predicts each new weight from the correspondence.

module tb;

    class weight_board;
        logic [15:0] pending[$];
        int          errors;

        function new();
            errors = 0;
        endfunction

        // Note an accepted correspondence's predicted weight.
        function void note_item(logic [15:0] w);
            pending.push_back(w);
        endfunction

        // Compare a returned weight against the oldest prediction.
        function void check_weight(logic [15:0] got);
            logic [15:0] exp_w;
            if (pending.size() == 0)
            begin
                $error("updated_weight: unexpected item, actual %0d", got);
                errors++;
                return;
            end
            exp_w = pending.pop_front();
            if (got !== exp_w)
            begin
                $error("updated_weight: expected %0d actual %0d", exp_w, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [31:0] model_x = '0, model_y = '0, model_z = '0;
    logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
    logic [15:0] old_weight = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [15:0] updated_weight;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    weight_board board = new();

    // Predictor's copy of the registers.
    logic [1:0]  pm_mode = rcr_pkg::MODE_BR;
    logic [30:0] pm_mu = rcr_pkg::MU_RESET;
    logic [30:0] pm_bound = rcr_pkg::BOUND_RESET;

    int  hold_cycles = 0;   // long receiver hold-off, counted down in the receiver process
    bit  random_stall = 0;

    always #4 clk = ~clk;

    robust_correspondence_reweight_core i_dut (.*);

    // Work out the new weight for one correspondence.
    function automatic logic [15:0] reweight(logic [31:0] mx, logic [31:0] my,
                                             logic [31:0] mz, logic [31:0] tx,
                                             logic [31:0] ty, logic [31:0] tz,
                                             logic [15:0] w);
        logic signed [33:0] d[3];
        logic [32:0] a;
        logic [32:0] m;
        logic [65:0] sq_sum;
        logic [127:0] res;
        logic [63:0] den, f, q, t;
        d[0] = 34'($signed(mx)) - 34'($signed(tx));
        d[1] = 34'($signed(my)) - 34'($signed(ty));
        d[2] = 34'($signed(mz)) - 34'($signed(tz));
        m = '0;
        sq_sum = '0;
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            a = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
            if (a > m) m = a;
            sq_sum += 66'(a) * 66'(a);
        end
        sq_sum = sq_sum >> 16;
        case (pm_mode)
            rcr_pkg::MODE_BR:
                if (w != 0)
                begin
                    den = 64'(sq_sum) + 64'(pm_mu);
                    f = (den == 0) ? 64'(rcr_pkg::WEIGHT_ONE) : (64'(pm_mu) << 15) / den;
                    if (f < 1) f = 1;
                    res = (128'(w) * f) >> 15;
                end
            rcr_pkg::MODE_HUB:
                if (m < pm_bound || m == 0) res = 128'(w);
                else res = (128'(w) * pm_bound) / m;
            rcr_pkg::MODE_BIS:
                if (m < pm_bound)
                begin
                    q = (64'(m) << 15) / pm_bound;
                    t = 64'(rcr_pkg::WEIGHT_ONE) - ((q * q) >> 15);
                    res = (128'(w) * t * t) >> 30;
                end
            default: res = '0;
        endcase
        return res > rcr_pkg::WEIGHT_ONE ? rcr_pkg::WEIGHT_ONE : res[15:0];
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rcr_pkg::REG_MODE:  pm_mode  = data[1:0];
            rcr_pkg::REG_MU:    pm_mu    = data[30:0];
            rcr_pkg::REG_BOUND: pm_bound = data[30:0];
            default: ;
        endcase
    endtask

    // Offer one correspondence; hold it until accepted.
    task automatic send_item(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                             logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                             logic [15:0] w);
        in_valid   <= 1'b1;
        model_x    <= mx;
        model_y    <= my;
        model_z    <= mz;
        target_x   <= tx;
        target_y   <= ty;
        target_z   <= tz;
        old_weight <= w;
        do @(posedge clk); while (in_stall);
        board.note_item(reweight(mx, my, mz, tx, ty, tz, w));
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int span);
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2 * span)) - span);
            2: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: return 32'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    // Near-target correspondences exercise the inner region of each estimator.
    task automatic random_item(bit gap);
        logic [31:0] mx, my, mz;
        logic [15:0] w;
        int span;
        span = $urandom_range(0, 3) == 0 ? 32'h0400_0000 : $urandom_range(1, 200000);
        mx = rand_coord(span);
        my = rand_coord(span);
        mz = rand_coord(span);
        case ($urandom_range(0, 7))
            0: w = 16'($urandom());
            1: w = 16'd0;
            2: w = rcr_pkg::WEIGHT_ONE;
            default: w = 16'($urandom_range(0, 32768));
        endcase
        if ($urandom_range(0, 2) == 0)
            send_item(mx, my, mz, rand_coord(span), rand_coord(span), rand_coord(span), w);
        else
            send_item(mx, my, mz,
                      mx + 32'($signed($urandom_range(0, 2 * span)) - span),
                      my + 32'($signed($urandom_range(0, 2 * span)) - span),
                      mz + 32'($signed($urandom_range(0, 2 * span)) - span), w);
        if (gap) idle_gap();
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            board.check_weight(updated_weight);
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_stall   <= 1'b1;
        end
        else if (random_stall)
            out_stall <= ($urandom_range(0, 29) == 0) ? 1'b1 : ($urandom_range(0, 3) == 0);
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        #8_000_000;
        $display("robust_correspondence_reweight_core regression: fail");
        $finish;
    end

    initial
    begin
        logic [31:0] mus[4];
        logic [31:0] bounds[4];
        mus = '{32'd1, 32'd65536, 32'h7fff_ffff, 32'd300};
        bounds = '{32'd65536, 32'd1, 32'h7fff_ffff, 32'd4_000_000};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset registers, extremes, zero weight, weight above one.
        send_item(0, 0, 0, 0, 0, 0, rcr_pkg::WEIGHT_ONE);
        send_item(0, 0, 0, 0, 0, 0, 16'hffff);
        send_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'hffff);
        send_item(32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0, rcr_pkg::WEIGHT_ONE);
        send_item(32'h10000, 0, 0, 0, 0, 0, 16'd0);
        send_item(32'h10000, 32'h8000, 0, 0, 0, 0, 16'd12345);
        drain();
        for (int md = 0; md < 4; md++)
        begin
            write_reg(rcr_pkg::REG_MODE, md);
            send_item(0, 0, 0, 0, 0, 0, 16'hffff);
            send_item(32'h10000, 0, 0, 0, 0, 0, rcr_pkg::WEIGHT_ONE);
            send_item(32'h8000, 0, 0, 0, 0, 0, 16'd20000);
            send_item(32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0, rcr_pkg::WEIGHT_ONE);
            drain();
        end
        // Zero scale and zero boundary cases.
        write_reg(rcr_pkg::REG_MU, 0);
        write_reg(rcr_pkg::REG_BOUND, 0);
        write_reg(rcr_pkg::REG_MODE, rcr_pkg::MODE_BR);
        send_item(5, 5, 5, 5, 5, 5, rcr_pkg::WEIGHT_ONE);
        drain();
        write_reg(rcr_pkg::REG_MODE, rcr_pkg::MODE_HUB);
        send_item(5, 5, 5, 5, 5, 5, 16'd777);
        drain();
        write_reg(rcr_pkg::REG_MODE, rcr_pkg::MODE_BIS);
        send_item(5, 5, 5, 5, 5, 5, 16'd777);
        drain();
        write_reg(2'd3, 32'hffff_ffff);   // beyond the register list: ignored

        // Random phases over modes 0 to 2 (a random mode in every fourth phase) and several settings.
        random_stall = 1;
        for (int ph = 0; ph < 12; ph++)
        begin
            write_reg(rcr_pkg::REG_MODE, ph % 4 == 3 ? $urandom_range(0, 3) : ph % 3);
            write_reg(rcr_pkg::REG_MU, ph < 4 ? mus[ph] : $urandom());
            write_reg(rcr_pkg::REG_BOUND, ph < 4 ? bounds[ph] :
                      ($urandom_range(0, 1) ? $urandom() : $urandom_range(1, 500000)));
            if (ph == 2)
            begin
                // Hold the output long enough to back the block up to in_stall.
                hold_cycles = 200;
                for (int k = 0; k < 80; k++) random_item(0);
            end
            for (int k = 0; k < 165; k++)
                random_item(ph % 4 != 1);
            if (ph == 5)
            begin
                // Sender waits for every outstanding result.
                in_valid <= 1'b0;
                while (board.pending.size() != 0) @(posedge clk);
            end
            drain();
        end

        if (board.errors == 0)
            $display("robust_correspondence_reweight_core regression: pass");
        else
            $display("robust_correspondence_reweight_core regression: fail");
        $finish;
    end
endmodule
